FILE: sv/tdpc_pkg.sv
// shared types and constants for the trial division prime counter
// no dependencies

package tdpc_pkg;

  localparam int unsigned VALUE_BITS = 20;
  localparam int unsigned COUNT_BITS = 16;
  // trial divisor reaches one above the integer square root
  localparam int unsigned D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  localparam int unsigned SQ_BITS    = VALUE_BITS + 1;
  localparam int unsigned IDX_BITS   = $clog2(VALUE_BITS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic                  is_prime;
    logic [COUNT_BITS-1:0] chunk_count;
    logic                  chunk_done;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } tdpc_state_e;

endpackage

FILE: sv/tdpc_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on tdpc_pkg

module tdpc_rem import tdpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [D_BITS-1:0]     divisor_i,
  output rem_status_t           status_o
);

  logic                busy_q, busy_d;
  logic [IDX_BITS-1:0] idx_q, idx_d;
  logic [D_BITS-1:0]   r_q, r_d;
  rem_status_t         status_q, status_d;
  logic [D_BITS:0]     trial;
  logic [D_BITS:0]     diff;
  logic                ge;

  always_comb begin
    trial    = {r_q, dividend_i[idx_q]};
    diff     = trial - {1'b0, divisor_i};
    ge       = trial >= {1'b0, divisor_i};
    busy_d   = busy_q;
    idx_d    = idx_q;
    r_d      = r_q;
    status_d = '0;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = IDX_BITS'(VALUE_BITS - 1);
      r_d    = '0;
    end else if (busy_q) begin
      r_d = ge ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
      if (idx_q == '0) begin
        busy_d        = 1'b0;
        status_d.done = 1'b1;
        status_d.zero = (r_d == '0);
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      status_q <= '0;
    end else begin
      busy_q   <= busy_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    r_q   <= r_d;
  end

  assign status_o = status_q;

endmodule

FILE: sv/trial_division_prime_counter.sv
// top level of the trial division prime counter
// depends on tdpc_pkg and tdpc_rem

// Tests each value for primality by trying divisors 2, 3, ... while d*d <= value,
// and reports the prime flag with the running prime count of the chunk (saturating,
// cleared after the item flagged last). One item is in work at a time; input ready
// is low until its result is in the output register. Each trial divisor is tested
// by the bit-serial remainder unit over all VALUE_BITS dividend bits, and values
// below 4 finish without any trial division.

module trial_division_prime_counter import tdpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  tdpc_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;
  logic [D_BITS-1:0]     div_q;
  logic [SQ_BITS-1:0]    sq_q;
  logic                  prime_q, prime_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q;
  rem_status_t           rem_status;
  logic                  accept;
  logic                  rem_start;
  logic                  load_out;
  logic                  below_two;
  logic                  sq_over;
  logic                  step_div;
  logic [COUNT_BITS-1:0] count_inc;

  assign below_two = value_q < VALUE_BITS'(2);
  assign sq_over   = sq_q > {1'b0, value_q};
  assign accept    = in_valid_i && in_ready_o;

  tdpc_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (value_q),
    .divisor_i  (div_q),
    .status_o   (rem_status)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = (below_two || sq_over) ? ST_FINISH : ST_DIV;
      ST_DIV: begin
        if (rem_status.done) state_d = rem_status.zero ? ST_FINISH : ST_CHECK;
      end
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    rem_start  = 1'b0;
    load_out   = 1'b0;
    step_div   = 1'b0;
    prime_d    = prime_q;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_CHECK: begin
        if (below_two) prime_d = 1'b0;
        else if (sq_over) prime_d = 1'b1;
        else rem_start = 1'b1;
      end
      ST_DIV: begin
        if (rem_status.done) begin
          if (rem_status.zero) prime_d = 1'b0;
          else step_div = 1'b1;
        end
      end
      ST_FINISH: load_out = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  // count and output register
  always_comb begin
    count_inc = count_q;
    if (prime_q && count_q != {COUNT_BITS{1'b1}}) count_inc = count_q + 1'b1;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      count_d     = last_q ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q <= prime_d;
    if (accept) begin
      value_q <= in_item_i.value;
      last_q  <= in_item_i.last;
      div_q   <= D_BITS'(2);
      sq_q    <= SQ_BITS'(4);
    end else if (step_div) begin
      div_q <= div_q + 1'b1;
      sq_q  <= sq_q + SQ_BITS'({div_q, 1'b1});
    end
    if (load_out) begin
      out_item_q.is_prime    <= prime_q;
      out_item_q.chunk_count <= count_inc;
      out_item_q.chunk_done  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: tb/prime_count_checker.sv
// checks the result stream of the trial division prime counter against its own prediction
// watches both valid/ready channels; depends on tdpc_pkg

module prime_count_checker import tdpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int unsigned            FIRST_PRIME   = 2;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;
  localparam int                     PRINT_LIMIT   = 60;

  out_item_t             expected_results[$];
  logic [COUNT_BITS-1:0] chunk_primes;
  int                    mismatches;
  out_item_t             want;

  function automatic logic trial_prime(input logic [VALUE_BITS-1:0] v);
    longint unsigned n;
    longint unsigned d;
    n = longint'(v);
    if (n < FIRST_PRIME) return 1'b0;
    for (d = FIRST_PRIME; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_primes = '0;
      mismatches   = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting: %p", out_item_i));
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.is_prime !== want.is_prime) begin
            report_mismatch($sformatf("is_prime %b, want %b",
                                      out_item_i.is_prime, want.is_prime));
          end
          if (out_item_i.chunk_count !== want.chunk_count) begin
            report_mismatch($sformatf("chunk_count %0d, want %0d",
                                      out_item_i.chunk_count, want.chunk_count));
          end
          if (out_item_i.chunk_done !== want.chunk_done) begin
            report_mismatch($sformatf("chunk_done %b, want %b",
                                      out_item_i.chunk_done, want.chunk_done));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want.is_prime = trial_prime(in_item_i.value);
        want.chunk_count = chunk_primes;
        if (want.is_prime && chunk_primes != COUNT_MAX) begin
          want.chunk_count = chunk_primes + 1'b1;
        end
        want.chunk_done = in_item_i.last;
        chunk_primes = in_item_i.last ? '0 : want.chunk_count;
        expected_results.push_back(want);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// stimulus and verdict for the trial division prime counter
// depends on tdpc_pkg, trial_division_prime_counter and prime_count_checker

module tb_top;
  import tdpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 12_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 38;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycles = 0;

  trial_division_prime_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  prime_count_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic l);
    in_item_t it;
    it.value = v;
    it.last  = l;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // mostly small values so the run stays short, a few across the full range
  task automatic send_random_chunks(input int unsigned n);
    logic [VALUE_BITS-1:0] v;
    int unsigned           pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) v = VALUE_BITS'($urandom());
      else if (pick < 20) v = VALUE_BITS'($urandom_range(65535));
      else v = VALUE_BITS'($urandom_range(4095));
      send_item(v, $urandom_range(5) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct <= 73;
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(4, 1'b1);
    send_item(1, 1'b1);
    send_item(2, 1'b1);
    send_item(5, 1'b0);
    send_item(25, 1'b0);
    send_item(49, 1'b0);
    send_item(97, 1'b0);
    send_item(121, 1'b1);
    send_item('1, 1'b0);
    send_item(1048573, 1'b0);
    // square of a prime sits right on the last trial divisor
    send_item(1018081, 1'b0);
    send_item(65537, 1'b1);
    send_item(0, 1'b1);
    send_item(3, 1'b1);
    send_item(1023, 1'b0);
    send_item(1021, 1'b0);
    send_item(524288, 1'b0);
    send_item(524287, 1'b1);

    send_idle_pct = 73;
    recv_idle_pct <= 20;
    send_random_chunks(RANDOM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    send_random_chunks(RANDOM_ITEMS);

    send_item(2, 1'b1);
    send_item(3, 1'b0);
    send_item(1, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: trial_division_prime_counter.f
sv/tdpc_pkg.sv
sv/tdpc_rem.sv
sv/trial_division_prime_counter.sv
tb/prime_count_checker.sv
tb/tb_top.sv
